// ----- sv/qpd_pkg.sv -----
// qpd_pkg: shared constants, types and helpers for the quad pick-and-drag block.
// No dependencies; the controller, datapath and top level take names from here by scope.
`default_nettype none
package qpd_pkg;
    localparam int FRAC_BITS = 14;
    localparam int CW = 16;
    localparam int PW = 12;
    localparam int TW = 14;
    // numerator width: (2p - s) * 2^F fits in PW+2+F bits signed
    localparam int NW = PW + 2 + FRAC_BITS;
    localparam int DIV_STEPS = NW;

    localparam logic [1:0] REQ_PRESS   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_MOTION  = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_TOL    = 2'd2;

    localparam logic [PW-1:0] RST_WIDTH  = 12'd800;
    localparam logic [PW-1:0] RST_HEIGHT = 12'd600;
    localparam logic [TW-1:0] RST_TOL    = 14'd819;

    localparam logic signed [CW-1:0] HALF =
        (FRAC_BITS - 1 >= 15) ? 16'sh7fff : CW'(1 << (FRAC_BITS - 1));

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIVX, ST_DIVY, ST_GRAB, ST_EDGE, ST_APPLY, ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start_x;
        logic div_start_y;
        logic div_step;
        logic grab_step;
        logic edge_step;
        logic apply;
        logic [1:0] idx;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_last;
        logic grab_hit;
        logic holding;
    } t_stat;

    function automatic logic signed [CW-1:0] sat16(input logic signed [CW+1:0] v);
        if (v > 18'sd32767) return 16'sh7fff;
        if (v < -18'sd32768) return 16'sh8000;
        return v[CW-1:0];
    endfunction
endpackage
`default_nettype wire

// ----- sv/qpd_ctrl.sv -----
// qpd_ctrl: sequencer for one request: two divisions, then for a press a grab walk and maybe an edge walk, apply.
// Depends on qpd_pkg.
`default_nettype none
module qpd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [1:0]    i_req,
    input  wire qpd_pkg::t_stat i_stat,
    output qpd_pkg::t_cmd      o_cmd,
    output logic               o_busy,
    output logic               o_done
);
    qpd_pkg::t_state r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic [1:0] r_req, n_req;

    // hold state, walk index and the request code taken at start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qpd_pkg::ST_IDLE;
            r_idx   <= 2'd0;
            r_req   <= qpd_pkg::REQ_PRESS;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_req   <= n_req;
        end
    end

    // advance through the request
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_req   = r_req;
        o_cmd   = '0;
        o_cmd.idx = r_idx;
        o_busy  = (r_state != qpd_pkg::ST_IDLE);
        o_done  = 1'b0;
        case (r_state)
            qpd_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    o_cmd.div_start_x = 1'b1;
                    n_req = i_req;
                    n_state = qpd_pkg::ST_DIVX;
                end
            end
            qpd_pkg::ST_DIVX: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    o_cmd.div_start_y = 1'b1;
                    n_state = qpd_pkg::ST_DIVY;
                end
            end
            qpd_pkg::ST_DIVY: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_idx = 2'd0;
                    n_state = (r_req == qpd_pkg::REQ_PRESS) ? qpd_pkg::ST_GRAB
                                                           : qpd_pkg::ST_APPLY;
                end
            end
            qpd_pkg::ST_GRAB: begin
                o_cmd.grab_step = 1'b1;
                n_idx = r_idx + 2'd1;
                if (i_stat.grab_hit || r_idx == 2'd3) begin
                    n_idx = 2'd0;
                    n_state = (i_stat.grab_hit || i_stat.holding) ? qpd_pkg::ST_APPLY
                                                                  : qpd_pkg::ST_EDGE;
                end
            end
            qpd_pkg::ST_EDGE: begin
                o_cmd.edge_step = 1'b1;
                n_idx = r_idx + 2'd1;
                if (r_idx == 2'd3) n_state = qpd_pkg::ST_APPLY;
            end
            qpd_pkg::ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = qpd_pkg::ST_DONE;
            end
            qpd_pkg::ST_DONE: begin
                o_done = 1'b1;
                n_state = qpd_pkg::ST_IDLE;
            end
            default: n_state = qpd_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- sv/qpd_dp.sv -----
// qpd_dp: datapath: config registers, restoring divider, grab and crossing
// units, corner store. Depends on qpd_pkg.
`default_nettype none
module qpd_dp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [13:0]           i_cfg_data,
    input  wire logic [1:0]            i_req,
    input  wire logic [qpd_pkg::PW-1:0] i_px,
    input  wire logic [qpd_pkg::PW-1:0] i_py,
    input  wire qpd_pkg::t_cmd         i_cmd,
    output qpd_pkg::t_stat             o_stat,
    output logic                       o_drag,
    output logic                       o_hold,
    output logic [1:0]                 o_index,
    output logic [8*qpd_pkg::CW-1:0]   o_corners
);
    localparam int CW = qpd_pkg::CW;
    localparam int NW = qpd_pkg::NW;

    logic [qpd_pkg::PW-1:0] r_w, r_h;
    logic [qpd_pkg::TW-1:0] r_tol;
    logic signed [CW-1:0] r_c [8];
    logic r_drag, r_hold;
    logic [1:0] r_hidx;
    logic signed [CW-1:0] r_lx, r_ly;
    logic [1:0] r_req;
    logic [qpd_pkg::PW-1:0] r_py;
    logic signed [CW-1:0] r_nx, r_ny;
    logic r_hit, r_par;
    logic [1:0] r_gidx;

    // divider state: magnitude quotient, remainder, sign
    logic [NW-1:0] r_num, r_quo;
    logic [qpd_pkg::PW:0] r_rem;
    logic [qpd_pkg::PW-1:0] r_den;
    logic r_neg, r_isy;
    logic [$clog2(qpd_pkg::DIV_STEPS+1)-1:0] r_cnt;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= qpd_pkg::RST_WIDTH;
            r_h <= qpd_pkg::RST_HEIGHT;
            r_tol <= qpd_pkg::RST_TOL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qpd_pkg::CFG_WIDTH:  r_w <= i_cfg_data[11:0];
                qpd_pkg::CFG_HEIGHT: r_h <= i_cfg_data[11:0];
                qpd_pkg::CFG_TOL:    r_tol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // divider set-up: |2p - s| << F over s
    function automatic logic [NW:0] numer(input logic [11:0] p, input logic [11:0] s);
        logic signed [NW:0] d;
        d = (($signed({2'b0, p, 1'b0}) - $signed({3'b0, s})) <<< qpd_pkg::FRAC_BITS);
        return d;
    endfunction

    logic [11:0] w_sw, w_sh, w_den;
    logic [NW:0] w_n;
    logic [qpd_pkg::PW:0] w_trial;
    logic [qpd_pkg::PW:0] w_sub;
    logic signed [CW+1:0] w_q;
    assign w_sw = (r_w == '0) ? 12'd1 : r_w;
    assign w_sh = (r_h == '0) ? 12'd1 : r_h;
    assign w_den = i_cmd.div_start_x ? w_sw : w_sh;
    assign w_n = i_cmd.div_start_x ? numer(i_px, w_sw) : numer(r_py, w_sh);
    assign w_trial = {r_rem[qpd_pkg::PW-1:0], r_num[NW-1]};
    assign w_sub = w_trial - {1'b0, r_den};
    assign o_stat.div_last = (r_cnt == $bits(r_cnt)'(1));

    // quotient in signed form, saturated; tail bit arrives this cycle
    logic [NW-1:0] w_qfin;
    logic [NW+1:0] w_qs;
    assign w_qfin = {r_quo[NW-2:0], ~w_sub[qpd_pkg::PW]};
    assign w_qs = r_neg ? -{2'b0, w_qfin} : {2'b0, w_qfin};
    always_comb begin
        if (!r_neg && w_qfin > NW'(32767)) w_q = 18'sd32767;
        else if (r_neg && w_qfin > NW'(32768)) w_q = -18'sd32768;
        else w_q = w_qs[CW+1:0];
    end

    // grab compare for the indexed corner
    logic signed [CW:0] w_dx, w_dy;
    logic [CW:0] w_ax, w_ay;
    logic w_ghit;
    assign w_dx = $signed({r_nx[CW-1], r_nx}) - $signed({r_c[{i_cmd.idx, 1'b0}][CW-1],
                  r_c[{i_cmd.idx, 1'b0}]});
    assign w_dy = $signed({r_ny[CW-1], r_ny}) - $signed({r_c[{i_cmd.idx, 1'b1}][CW-1],
                  r_c[{i_cmd.idx, 1'b1}]});
    assign w_ax = w_dx[CW] ? -w_dx : w_dx;
    assign w_ay = w_dy[CW] ? -w_dy : w_dy;
    assign w_ghit = (w_ax < {3'b0, r_tol}) && (w_ay < {3'b0, r_tol});
    assign o_stat.grab_hit = w_ghit;
    assign o_stat.holding = r_hold;

    // edge crossing for edge idx -> idx+1
    logic [1:0] w_j;
    logic signed [CW-1:0] w_xi, w_yi, w_xj, w_yj;
    logic signed [CW:0] w_d, w_ex, w_ey, w_exj;
    logic signed [2*CW+1:0] w_lhs, w_rhs;
    logic w_strad, w_right;
    assign w_j = i_cmd.idx + 2'd1;
    assign w_xi = r_c[{i_cmd.idx, 1'b0}];
    assign w_yi = r_c[{i_cmd.idx, 1'b1}];
    assign w_xj = r_c[{w_j, 1'b0}];
    assign w_yj = r_c[{w_j, 1'b1}];
    assign w_d = w_yj - w_yi;
    assign w_ex = r_nx - w_xj;
    assign w_ey = r_ny - w_yj;
    assign w_exj = w_xj - w_xi;
    assign w_lhs = w_ex * w_d;
    assign w_rhs = w_ey * w_exj;
    assign w_strad = (r_ny < w_yi) != (r_ny < w_yj);
    assign w_right = w_d[CW] ? (w_lhs > w_rhs) : (w_lhs < w_rhs);

    // translation deltas
    logic signed [CW+1:0] w_ddx, w_ddy;
    assign w_ddx = r_nx - r_lx;
    assign w_ddy = r_ny - r_ly;

    // sequence the request through the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c[0] <= -qpd_pkg::HALF; r_c[1] <= qpd_pkg::HALF;
            r_c[2] <= qpd_pkg::HALF;  r_c[3] <= qpd_pkg::HALF;
            r_c[4] <= qpd_pkg::HALF;  r_c[5] <= -qpd_pkg::HALF;
            r_c[6] <= -qpd_pkg::HALF; r_c[7] <= -qpd_pkg::HALF;
            r_drag <= 1'b0; r_hold <= 1'b0; r_hidx <= 2'd0;
            r_lx <= '0; r_ly <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_req <= i_req;
                r_py  <= i_py;
                r_hit <= 1'b0;
                r_par <= 1'b0;
            end
            // store the finished quotient
            if (i_cmd.div_step && o_stat.div_last) begin
                if (r_isy) r_ny <= qpd_pkg::sat16(-w_q);
                else r_nx <= w_q[CW-1:0];
            end
            // load a new division, or advance the running one
            if (i_cmd.div_start_x || i_cmd.div_start_y) begin
                r_num <= w_n[NW] ? -w_n[NW-1:0] : w_n[NW-1:0];
                r_neg <= w_n[NW];
                r_den <= w_den;
                r_rem <= '0;
                r_quo <= '0;
                r_isy <= i_cmd.div_start_y;
                r_cnt <= ($clog2(qpd_pkg::DIV_STEPS+1))'(qpd_pkg::DIV_STEPS);
            end else if (i_cmd.div_step) begin
                r_num <= r_num << 1;
                r_rem <= w_sub[qpd_pkg::PW] ? w_trial : w_sub;
                r_quo <= w_qfin;
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.grab_step && w_ghit) begin
                r_hit <= 1'b1;
                r_gidx <= i_cmd.idx;
            end
            if (i_cmd.edge_step && w_strad && w_right) r_par <= ~r_par;
            if (i_cmd.apply) begin
                case (r_req)
                    qpd_pkg::REQ_PRESS: begin
                        r_lx <= r_nx; r_ly <= r_ny;
                        if (r_hit) begin
                            r_hold <= 1'b1; r_hidx <= r_gidx; r_drag <= 1'b1;
                        end else begin
                            r_drag <= r_hold | r_par;
                        end
                    end
                    qpd_pkg::REQ_RELEASE: begin
                        r_drag <= 1'b0; r_hold <= 1'b0;
                    end
                    qpd_pkg::REQ_MOTION: begin
                        if (r_drag) begin
                            if (r_hold) begin
                                r_c[{r_hidx, 1'b0}] <= r_nx;
                                r_c[{r_hidx, 1'b1}] <= r_ny;
                            end else begin
                                for (int k = 0; k < 4; k++) begin
                                    r_c[2*k] <= qpd_pkg::sat16(r_c[2*k] + w_ddx);
                                    r_c[2*k+1] <= qpd_pkg::sat16(r_c[2*k+1] + w_ddy);
                                end
                                r_lx <= r_nx; r_ly <= r_ny;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_drag = r_drag;
    assign o_hold = r_hold;
    assign o_index = r_hold ? r_hidx : 2'd0;
    always_comb begin
        for (int k = 0; k < 8; k++) o_corners[k*CW +: CW] = r_c[k];
    end
endmodule
`default_nettype wire

// ----- sv/quad_pick_and_drag_top.sv -----
// quad_pick_and_drag_top: top level joining the controller and datapath.
// Depends on qpd_pkg, qpd_ctrl, qpd_dp.
`default_nettype none
// One request at a time: start is taken when busy is low. The result strobe
// o_valid comes after two 28-step bit-serial divisions that map the pointer
// axes, then an apply step, for release, motion and the unused code. A press
// adds, between the divisions and the apply, a grab walk over the corners that
// stops at a hit and, when nothing is grabbed or held, a crossing walk over every edge.
// Busy drops the cycle after the strobe, so a new request is taken only once
// the last result is out. The result cannot be held off; the corner and drag
// outputs also hold the current state between results.
module quad_pick_and_drag_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [13:0] i_cfg_data,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [11:0] i_pointer_x,
    input  wire logic [11:0] i_pointer_y,
    output logic             o_valid,
    output logic             o_drag_active,
    output logic             o_vertex_grabbed,
    output logic [1:0]       o_grabbed_index,
    output logic signed [15:0] o_corner0_x, o_corner0_y, o_corner1_x, o_corner1_y,
    output logic signed [15:0] o_corner2_x, o_corner2_y, o_corner3_x, o_corner3_y
);
    qpd_pkg::t_cmd  w_cmd;
    qpd_pkg::t_stat w_stat;
    logic [8*qpd_pkg::CW-1:0] w_c;

    qpd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_req(i_req_type),
        .i_stat(w_stat), .o_cmd(w_cmd), .o_busy(busy), .o_done(o_valid)
    );

    qpd_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_req(i_req_type), .i_px(i_pointer_x),
        .i_py(i_pointer_y), .i_cmd(w_cmd), .o_stat(w_stat), .o_drag(o_drag_active),
        .o_hold(o_vertex_grabbed), .o_index(o_grabbed_index), .o_corners(w_c)
    );

    assign o_corner0_x = w_c[15:0];    assign o_corner0_y = w_c[31:16];
    assign o_corner1_x = w_c[47:32];   assign o_corner1_y = w_c[63:48];
    assign o_corner2_x = w_c[79:64];   assign o_corner2_y = w_c[95:80];
    assign o_corner3_x = w_c[111:96];  assign o_corner3_y = w_c[127:112];
endmodule
`default_nettype wire

// ----- sv/qpd_checker.sv -----
// qpd_checker: port-level assertions for quad_pick_and_drag_top, with bind.
// Depends on the top level's ports only.
`default_nettype none
module qpd_port_checks (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_valid,
    input wire logic       o_drag_active,
    input wire logic       o_vertex_grabbed,
    input wire logic [1:0] o_grabbed_index
);
    // a request makes the block busy next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request not taken");
    // a result ends the request
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy) else $error("busy after result");
    // a held vertex implies a drag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vertex_grabbed |-> o_drag_active) else $error("hold without drag");
    // index is zero when nothing is held
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_vertex_grabbed |-> (o_grabbed_index == 2'd0)) else $error("stray index");
endmodule

bind quad_pick_and_drag_top qpd_port_checks u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_valid(o_valid),
    .o_drag_active(o_drag_active), .o_vertex_grabbed(o_vertex_grabbed),
    .o_grabbed_index(o_grabbed_index)
);
`default_nettype wire
